/* rtl/unwrapped_planar_angle_tracker_macros.svh */
// assertion macros for the angle tracker
`ifndef UNWRAPPED_PLANAR_ANGLE_TRACKER_MACROS_SVH
`define UNWRAPPED_PLANAR_ANGLE_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define UPAT_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("upat invariant violated");
`define UPAT_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("upat sequence violated");
`else
`define UPAT_ASSERT_ALWAYS(label, clk, rst, cond)
`define UPAT_ASSERT_NEXT(label, clk, rst, trig, cond)
`endif
`endif

/* rtl/upat_pkg.sv */
`default_nettype none
package upat_pkg;

  localparam int CW           = 32;
  localparam int AFB          = 24;
  localparam int CORDIC_STEPS = 24;
  localparam int COORD_FRAC   = 24;
  localparam int QUOT_FRAC    = 24;
  localparam int ACC_FRAC     = 48;
  localparam int AW           = 48;
  localparam int SH           = ACC_FRAC - AFB;
  localparam int GUARD        = 60 - CW;
  localparam int CORD_W       = 64;
  localparam int QBITS        = 49;
  localparam int DIV_W        = 4 * CW + QBITS - 1;
  localparam int CNT_W        = $clog2(QBITS);
  localparam int IDX_W        = $clog2(CORDIC_STEPS);
  localparam int N_SH_LIN     = COORD_FRAC + QUOT_FRAC + 1;
  localparam int N_SH_SQ      = 2 * COORD_FRAC + QUOT_FRAC + 1;

  localparam logic [AW-1:0] Q_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic [AW-1:0] Q_MIN = {1'b1, {(AW-1){1'b0}}};
  localparam logic [63:0]   ONE60 = 64'd1 << 60;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RUN, ST_LOAD, ST_DIV, ST_DONE
  } upat_state_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_XX, MUL_YY, MUL_XY, MUL_SUM, MUL_LL, MUL_HL, MUL_HH
  } mul_op_t;

  typedef struct packed {
    logic             load;
    logic             run;
    logic [IDX_W-1:0] idx;
    mul_op_t          mul_op;
    logic             div_load;
    logic             div_step;
    logic             capture;
  } upat_cmd_t;

  typedef struct packed {
    logic signed [AW-1:0] angle_turns;
    logic signed [AW-1:0] cos_over_r2;
    logic signed [AW-1:0] sin_over_r2;
    logic signed [AW-1:0] two_xy_over_r4;
    logic signed [AW-1:0] diff_sq_over_r4;
    logic                 zero_radius;
  } upat_res_t;

  typedef logic [CORDIC_STEPS-1:0][ACC_FRAC-1:0] ang_tab_t;

  // restoring long division, elaboration only
  function automatic logic [63:0] cdiv(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) in radians, 60 fraction bits
  function automatic logic [63:0] atan_inv(input logic [63:0] n);
    logic [63:0] power;
    logic [63:0] acc;
    logic [63:0] term;
    power = cdiv(ONE60, n);
    acc   = '0;
    for (int k = 0; k < 64; k++) begin
      if (power != 64'd0) begin
        term = cdiv(power, 64'(2 * k + 1));
        if (k[0]) acc = acc - term;
        else acc = acc + term;
        power = cdiv(cdiv(power, n), n);
      end
    end
    return acc;
  endfunction

  // per-step rotation angles in turns, 48 fraction bits
  function automatic ang_tab_t build_ang_tab();
    logic [63:0] pi60;
    logic [63:0] twopi;
    logic [63:0] rem;
    logic [63:0] q;
    ang_tab_t    t;
    pi60  = 64'd16 * atan_inv(64'd5) - 64'd4 * atan_inv(64'd239);
    twopi = pi60 << 1;
    t     = '0;
    t[0]  = ACC_FRAC'(64'd1 << (ACC_FRAC - 3));
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      rem = atan_inv(64'd1 << i);
      q   = '0;
      for (int b = 0; b <= ACC_FRAC; b++) begin
        rem = rem << 1;
        q   = q << 1;
        if (rem >= twopi) begin
          rem  = rem - twopi;
          q[0] = 1'b1;
        end
      end
      t[i] = ACC_FRAC'((q + 64'd1) >> 1);
    end
    return t;
  endfunction

  localparam ang_tab_t ANG_TAB = build_ang_tab();

endpackage
`default_nettype wire

/* rtl/upat_if.sv */
`default_nettype none
interface upat_vec_if import upat_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] x_coord;
  logic signed [CW-1:0] y_coord;
  modport source (output valid, x_coord, y_coord, input ready);
  modport sink (input valid, x_coord, y_coord, output ready);
endinterface

interface upat_res_if import upat_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [AW-1:0] angle_turns;
  logic signed [AW-1:0] cos_over_r2;
  logic signed [AW-1:0] sin_over_r2;
  logic signed [AW-1:0] two_xy_over_r4;
  logic signed [AW-1:0] diff_sq_over_r4;
  logic                 zero_radius;
  modport source (output valid, angle_turns, cos_over_r2, sin_over_r2, two_xy_over_r4,
                  diff_sq_over_r4, zero_radius, input ready);
  modport sink (input valid, angle_turns, cos_over_r2, sin_over_r2, two_xy_over_r4,
                diff_sq_over_r4, zero_radius, output ready);
endinterface
`default_nettype wire

/* rtl/unwrapped_planar_angle_tracker.sv */
// flow: one item at a time; a new input beat is taken only once the previous result
//   has been captured, after the 24-step cordic and the 49-step restoring dividers
//   that follow it (one quotient bit per cycle)
// reset: synchronous, active high; clears the controller, the output valid,
//   the tracked angle and its set flag
`default_nettype none
`include "unwrapped_planar_angle_tracker_macros.svh"
module unwrapped_planar_angle_tracker import upat_pkg::*; (
  input logic        clk,
  input logic        rst,
  upat_vec_if.sink   vec,
  upat_res_if.source res
);

  // controller to datapath command bundle
  upat_cmd_t cmd;
  // registered result payload
  upat_res_t rres;
  logic      out_valid;

  // sequencer: idle, cordic plus multiplies, divider load, divide, hand over
  upat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vec.valid),
    .in_ready  (vec.ready),
    .out_ready (res.ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // cordic, shared 32x32 multiplier, four divider lanes, angle unwrap
  upat_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .x_coord (vec.x_coord),
    .y_coord (vec.y_coord),
    .res     (rres)
  );

  // result beat straight from the output register
  assign res.valid           = out_valid;
  assign res.angle_turns     = rres.angle_turns;
  assign res.cos_over_r2     = rres.cos_over_r2;
  assign res.sin_over_r2     = rres.sin_over_r2;
  assign res.two_xy_over_r4  = rres.two_xy_over_r4;
  assign res.diff_sq_over_r4 = rres.diff_sq_over_r4;
  assign res.zero_radius     = rres.zero_radius;

  // no second item is taken straight after one is accepted
  `UPAT_ASSERT_NEXT(a_no_back_to_back, clk, rst, vec.valid && vec.ready, !vec.ready)
  // the output register is only overwritten once its beat has gone
  `UPAT_ASSERT_ALWAYS(a_capture_free, clk, rst, !cmd.capture || !res.valid || res.ready)
  // a zero radius result carries saturated quotients
  `UPAT_ASSERT_ALWAYS(a_zero_sat, clk, rst,
    !(res.valid && res.zero_radius) || (res.cos_over_r2 == Q_MAX && res.diff_sq_over_r4 == Q_MAX))

endmodule
`default_nettype wire

/* rtl/upat_div.sv */
`default_nettype none
module upat_div import upat_pkg::*; (
  input  logic                 clk,
  input  logic                 load,
  input  logic                 step,
  input  logic [DIV_W-1:0]     num,
  input  logic [DIV_W-1:0]     den_sh,
  input  logic                 neg,
  output logic signed [AW-1:0] quo
);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] ds;
  logic [QBITS-1:0] mag;
  logic             neg_r;

  localparam logic [QBITS-1:0] TOP = QBITS'(1) << (AW - 1);

  // one quotient bit a cycle while step is high, most significant first
  always_ff @(posedge clk) begin
    if (load) begin
      rem   <= num;
      ds    <= den_sh;
      mag   <= '0;
      neg_r <= neg;
    end else if (step) begin
      if (rem >= ds) begin
        rem <= rem - ds;
        mag <= {mag[QBITS-2:0], 1'b1};
      end else begin
        mag <= {mag[QBITS-2:0], 1'b0};
      end
      ds <= ds >> 1;
    end
  end

  // signed result with saturation
  always_comb begin
    if (neg_r) begin
      quo = (mag > TOP) ? Q_MIN : AW'(~mag + QBITS'(1));
    end else begin
      quo = (mag >= TOP) ? Q_MAX : mag[AW-1:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/upat_dp.sv */
`default_nettype none
module upat_dp import upat_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  upat_cmd_t            cmd,
  input  logic signed [CW-1:0] x_coord,
  input  logic signed [CW-1:0] y_coord,
  output upat_res_t            res
);

  logic [CW-1:0]             ax, ay;
  logic                      x_neg, y_neg, x_pos, is_zero;
  logic signed [CORD_W-1:0]  cx, cy;
  logic [ACC_FRAC-1:0]       cz;
  logic [2*CW-1:0]           sx2, sy2, pxy, r2, df;
  logic                      dneg;
  logic [4*CW-1:0]           r4;
  logic signed [AW-1:0]      tracked;
  logic                      ang_valid;

  logic signed [CORD_W-1:0]  xe, ye, dx, dy;
  logic [CW-1:0]             ma, mb;
  logic [2*CW-1:0]           prod;

  logic signed [ACC_FRAC:0]  s_init;
  logic [ACC_FRAC:0]         s_wr;
  logic signed [AW-1:0]      init_angle;
  logic [AFB-1:0]            a_wr;
  logic [AW:0]               dd;
  logic                      inc;
  logic [AW-AFB-1:0]         kk;
  logic signed [AW-1:0]      unwrap;

  logic signed [AW-1:0]      q_c, q_s, q_p, q_q;
  logic [DIV_W-1:0]          n_c, n_s, n_p, n_q, ds_r2, ds_r4;

  localparam logic [AFB-1:0] HALF = AFB'(1) << (AFB - 1);

  assign xe = CORD_W'(x_coord) <<< GUARD;
  assign ye = CORD_W'(y_coord) <<< GUARD;
  assign dx = cx >>> cmd.idx;
  assign dy = cy >>> cmd.idx;

  // shared multiplier operands
  always_comb begin
    unique case (cmd.mul_op)
      MUL_YY: begin
        ma = ay;
        mb = ay;
      end
      MUL_XY: begin
        ma = ax;
        mb = ay;
      end
      MUL_LL: begin
        ma = r2[CW-1:0];
        mb = r2[CW-1:0];
      end
      MUL_HL: begin
        ma = r2[2*CW-1:CW];
        mb = r2[CW-1:0];
      end
      MUL_HH: begin
        ma = r2[2*CW-1:CW];
        mb = r2[2*CW-1:CW];
      end
      default: begin
        ma = ax;
        mb = ax;
      end
    endcase
  end
  assign prod = ma * mb;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_neg   <= x_coord[CW-1];
      y_neg   <= y_coord[CW-1];
      x_pos   <= !x_coord[CW-1] && (x_coord != '0);
      is_zero <= (x_coord == '0) && (y_coord == '0);
      ax      <= x_coord[CW-1] ? CW'(-x_coord) : CW'(x_coord);
      ay      <= y_coord[CW-1] ? CW'(-y_coord) : CW'(y_coord);
      if (x_coord[CW-1]) begin
        cx <= -xe;
        cy <= -ye;
        cz <= ACC_FRAC'(1) << (ACC_FRAC - 1);
      end else begin
        cx <= xe;
        cy <= ye;
        cz <= '0;
      end
    end else if (cmd.run) begin
      if (!cy[CORD_W-1]) begin
        cx <= cx + dy;
        cy <= cy - dx;
        cz <= cz + ANG_TAB[cmd.idx];
      end else begin
        cx <= cx - dy;
        cy <= cy + dx;
        cz <= cz - ANG_TAB[cmd.idx];
      end
      unique case (cmd.mul_op)
        MUL_XX: sx2 <= prod;
        MUL_YY: sy2 <= prod;
        MUL_XY: pxy <= prod;
        MUL_SUM: begin
          r2   <= sx2 + sy2;
          dneg <= sy2 < sx2;
          df   <= (sy2 >= sx2) ? sy2 - sx2 : sx2 - sy2;
        end
        MUL_LL: r4 <= {{(2*CW){1'b0}}, prod};
        MUL_HL: r4 <= r4 + ({{(2*CW){1'b0}}, prod} << (CW + 1));
        MUL_HH: r4 <= r4 + {prod, {(2*CW){1'b0}}};
        MUL_NONE: ;
      endcase
    end
  end

  // angle update: first set or nearest branch
  assign s_init     = $signed({cz[ACC_FRAC-1], cz}) + $signed((ACC_FRAC+1)'(1) << (SH - 1));
  assign init_angle = AW'(s_init >>> SH);
  assign s_wr       = {1'b0, cz} + ((ACC_FRAC+1)'(1) << (SH - 1));
  assign a_wr       = s_wr[SH+AFB-1:SH];
  assign dd         = {tracked[AW-1], tracked} - (AW+1)'(a_wr);
  assign inc        = (dd[AFB-1:0] > HALF) || ((dd[AFB-1:0] == HALF) && !dd[AW]);
  assign kk         = dd[AW-1:AFB] + (AW-AFB)'(inc);
  assign unwrap     = {kk, {AFB{1'b0}}} + AW'(a_wr);

  always_ff @(posedge clk) begin
    if (rst) begin
      tracked   <= '0;
      ang_valid <= 1'b0;
    end else if (cmd.div_load && !is_zero) begin
      ang_valid <= 1'b1;
      priority if (!ang_valid && x_pos) tracked <= init_angle;
      else if (!ang_valid) tracked <= AW'(a_wr);
      else tracked <= unwrap;
    end
  end

  // divider operands, rounded quotient = (num<<k+1 + den) / (2 den)
  assign n_c   = (DIV_W'(ax) << N_SH_LIN) + DIV_W'(r2);
  assign n_s   = (DIV_W'(ay) << N_SH_LIN) + DIV_W'(r2);
  assign n_p   = (DIV_W'(pxy) << (N_SH_SQ + 1)) + DIV_W'(r4);
  assign n_q   = (DIV_W'(df) << N_SH_SQ) + DIV_W'(r4);
  assign ds_r2 = DIV_W'(r2) << QBITS;
  assign ds_r4 = DIV_W'(r4) << QBITS;

  upat_div u_div_c (
    .clk(clk), .load(cmd.div_load), .step(cmd.div_step),
    .num(n_c), .den_sh(ds_r2), .neg(x_neg), .quo(q_c)
  );
  upat_div u_div_s (
    .clk(clk), .load(cmd.div_load), .step(cmd.div_step),
    .num(n_s), .den_sh(ds_r2), .neg(y_neg), .quo(q_s)
  );
  upat_div u_div_p (
    .clk(clk), .load(cmd.div_load), .step(cmd.div_step),
    .num(n_p), .den_sh(ds_r4), .neg(x_neg ^ y_neg), .quo(q_p)
  );
  upat_div u_div_q (
    .clk(clk), .load(cmd.div_load), .step(cmd.div_step),
    .num(n_q), .den_sh(ds_r4), .neg(dneg), .quo(q_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res.angle_turns     <= tracked;
      res.cos_over_r2     <= is_zero ? Q_MAX : q_c;
      res.sin_over_r2     <= is_zero ? Q_MAX : q_s;
      res.two_xy_over_r4  <= is_zero ? Q_MAX : q_p;
      res.diff_sq_over_r4 <= is_zero ? Q_MAX : q_q;
      res.zero_radius     <= is_zero;
    end
  end

endmodule
`default_nettype wire

/* rtl/upat_ctrl.sv */
`default_nettype none
module upat_ctrl import upat_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  output upat_cmd_t cmd
);

  upat_state_t      state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_RUN;
      ST_RUN:  if (cnt == CNT_W'(CORDIC_STEPS - 1)) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_DIV;
      ST_DIV:  if (cnt == CNT_W'(QBITS - 1)) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.idx  = cnt[IDX_W-1:0];
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RUN: begin
        cmd.run = 1'b1;
        unique case (cnt)
          CNT_W'(0): cmd.mul_op = MUL_XX;
          CNT_W'(1): cmd.mul_op = MUL_YY;
          CNT_W'(2): cmd.mul_op = MUL_XY;
          CNT_W'(3): cmd.mul_op = MUL_SUM;
          CNT_W'(4): cmd.mul_op = MUL_LL;
          CNT_W'(5): cmd.mul_op = MUL_HL;
          CNT_W'(6): cmd.mul_op = MUL_HH;
          default:   cmd.mul_op = MUL_NONE;
        endcase
      end
      ST_LOAD: cmd.div_load = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_DONE: cmd.capture = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if ((state == ST_RUN || state == ST_DIV) && state_next == state) cnt <= cnt + CNT_W'(1);
      else cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.capture) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

endmodule
`default_nettype wire
